// ===== rtl/hse_pkg.sv =====
// shared types and constants for the heap sort engine
package hse_pkg;

   localparam int CAPACITY = 32;
   localparam int KEY_W    = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             last_item;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic             last_result;
      logic             overflow;
   } rsp_type;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   typedef enum logic [11:0] {
      ST_LOAD      = 12'b0000_0000_0001,
      ST_SD_NODE   = 12'b0000_0000_0010,
      ST_SD_CAP    = 12'b0000_0000_0100,
      ST_SD_LC     = 12'b0000_0000_1000,
      ST_SD_RC     = 12'b0000_0001_0000,
      ST_SD_CMP    = 12'b0000_0010_0000,
      ST_TASK_DONE = 12'b0000_0100_0000,
      ST_EX_ROOT   = 12'b0000_1000_0000,
      ST_EX_TAIL   = 12'b0001_0000_0000,
      ST_EX_SWAP   = 12'b0010_0000_0000,
      ST_EM_RD     = 12'b0100_0000_0000,
      ST_EM_OUT    = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== rtl/hse_key_ram.sv =====
// single-port-write, single-port-read key memory with registered read data
module hse_key_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hse_ctrl.sv =====
// sequencer: loads keys, runs heap build and extraction on the key memory, reads out
module hse_ctrl
   import hse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  req_type           req_data,
   output logic              req_stall,
   input  logic              out_free,
   output emit_type          emit,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [KEY_W-1:0]  mem_wr_data,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [KEY_W-1:0]  mem_rd_data
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               build_ff, build_in;
   logic [CNT_W-1:0]   bi_ff, bi_in;
   logic [CNT_W-1:0]   ei_ff, ei_in;
   logic [CNT_W-1:0]   size_ff, size_in;
   logic [ADDR_W-1:0]  node_ff, node_in;
   logic [KEY_W-1:0]   cur_key_ff, cur_key_in;
   logic [KEY_W-1:0]   lkey_ff, lkey_in;
   logic               rc_ok_ff, rc_ok_in;
   logic [ADDR_W-1:0]  j_ff, j_in;

   logic [CHILD_W-1:0] lc, rc, size_ext;
   logic               lc_ok, rc_ok;
   logic               has_room, bigger_l, bigger_r;
   logic [KEY_W-1:0]   bkey_l, bkey;
   logic [ADDR_W-1:0]  big_idx;
   logic [CNT_W-1:0]   count_next, n_half, bi_dec, bi_dec2, ei_dec, j_inc;

   // first build node is half the count minus one
   function automatic logic [ADDR_W-1:0] bi_in_node(input logic [CNT_W-1:0] half);
      logic [CNT_W-1:0] idx;
      idx = half - CNT_W'(1);
      return idx[ADDR_W-1:0];
   endfunction

   // child indices of the current node, wide enough not to wrap
   assign lc       = {1'b0, node_ff, 1'b1};
   assign rc       = {1'b0, node_ff, 1'b0} + CHILD_W'(2);
   assign size_ext = CHILD_W'(size_ff);
   assign lc_ok    = lc < size_ext;
   assign rc_ok    = rc < size_ext;

   assign has_room   = count_ff < CNT_W'(CAPACITY);
   assign count_next = count_ff + CNT_W'(has_room);
   assign n_half     = count_next >> 1;
   assign bi_dec     = bi_ff - CNT_W'(1);
   assign bi_dec2    = bi_ff - CNT_W'(2);
   assign ei_dec     = ei_ff - CNT_W'(1);
   assign j_inc      = CNT_W'(j_ff) + CNT_W'(1);

   // pick the larger child; ties keep the parent or the left child
   assign bigger_l = lkey_ff > cur_key_ff;
   assign bkey_l   = bigger_l ? lkey_ff : cur_key_ff;
   assign bigger_r = rc_ok_ff && (mem_rd_data > bkey_l);
   assign bkey     = bigger_r ? mem_rd_data : lkey_ff;
   assign big_idx  = bigger_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

   assign req_stall = (state_ff != ST_LOAD);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      build_in    = build_ff;
      bi_in       = bi_ff;
      ei_in       = ei_ff;
      size_in     = size_ff;
      node_in     = node_ff;
      cur_key_in  = cur_key_ff;
      lkey_in     = lkey_ff;
      rc_ok_in    = rc_ok_ff;
      j_in        = j_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = node_ff;
      mem_wr_data = cur_key_ff;
      mem_rd_addr = '0;
      emit.valid  = 1'b0;
      emit.data.sorted_key  = mem_rd_data;
      emit.data.last_result = (j_inc == count_ff);
      emit.data.overflow    = ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               mem_wr_en   = has_room;
               mem_wr_addr = count_ff[ADDR_W-1:0];
               mem_wr_data = req_data.key;
               count_in    = count_next;
               ovf_in      = ovf_ff | ~has_room;
               if (req_data.last_item) begin
                  size_in = count_next;
                  j_in    = '0;
                  if (n_half != '0) begin
                     build_in = 1'b1;
                     bi_in    = n_half;
                     node_in  = bi_in_node(n_half);
                     state_in = ST_SD_NODE;
                  end else begin
                     state_in = ST_EM_RD;
                  end
               end
            end
         end
         ST_SD_NODE: begin
            mem_rd_addr = node_ff;
            state_in    = ST_SD_CAP;
         end
         ST_SD_CAP: begin
            cur_key_in = mem_rd_data;
            state_in   = ST_SD_LC;
         end
         ST_SD_LC: begin
            if (lc_ok) begin
               mem_rd_addr = lc[ADDR_W-1:0];
               state_in    = ST_SD_RC;
            end else begin
               // leaf reached: the sifted key lands here
               mem_wr_en = 1'b1;
               state_in  = ST_TASK_DONE;
            end
         end
         ST_SD_RC: begin
            lkey_in     = mem_rd_data;
            rc_ok_in    = rc_ok;
            mem_rd_addr = rc[ADDR_W-1:0];
            state_in    = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            mem_wr_en = 1'b1;
            if (bigger_l || bigger_r) begin
               // larger child moves up, sifted key stays in a register
               mem_wr_data = bkey;
               node_in     = big_idx;
               state_in    = ST_SD_LC;
            end else begin
               state_in = ST_TASK_DONE;
            end
         end
         ST_TASK_DONE: begin
            if (build_ff) begin
               if (bi_ff > CNT_W'(1)) begin
                  bi_in    = bi_dec;
                  node_in  = bi_dec2[ADDR_W-1:0];
                  state_in = ST_SD_NODE;
               end else begin
                  build_in = 1'b0;
                  ei_in    = count_ff;
                  state_in = ST_EX_ROOT;
               end
            end else begin
               ei_in = ei_dec;
               if (ei_dec > CNT_W'(1)) begin
                  state_in = ST_EX_ROOT;
               end else begin
                  j_in     = '0;
                  state_in = ST_EM_RD;
               end
            end
         end
         ST_EX_ROOT: begin
            mem_rd_addr = '0;
            state_in    = ST_EX_TAIL;
         end
         ST_EX_TAIL: begin
            lkey_in     = mem_rd_data;
            mem_rd_addr = ei_dec[ADDR_W-1:0];
            state_in    = ST_EX_SWAP;
         end
         ST_EX_SWAP: begin
            // root goes to the tail, tail key sifts down from the root
            cur_key_in  = mem_rd_data;
            mem_wr_en   = 1'b1;
            mem_wr_addr = ei_dec[ADDR_W-1:0];
            mem_wr_data = lkey_ff;
            node_in     = '0;
            size_in     = ei_dec;
            state_in    = ST_SD_LC;
         end
         ST_EM_RD: begin
            mem_rd_addr = j_ff;
            state_in    = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            mem_rd_addr = j_ff;
            if (out_free) begin
               emit.valid  = 1'b1;
               mem_rd_addr = j_inc[ADDR_W-1:0];
               j_in        = j_inc[ADDR_W-1:0];
               if (j_inc == count_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         build_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         build_ff <= build_in;
      end
   end

   always_ff @(posedge clock) begin
      bi_ff      <= bi_in;
      ei_ff      <= ei_in;
      size_ff    <= size_in;
      node_ff    <= node_in;
      cur_key_ff <= cur_key_in;
      lkey_ff    <= lkey_in;
      rc_ok_ff   <= rc_ok_in;
      j_ff       <= j_in;
   end

endmodule

// ===== rtl/heap_sort_engine.sv =====
// top level of the heap sort engine
//
// Collects unsigned 16-bit keys on the req_ channel, one transfer per cycle, into
// a key memory of CAPACITY entries. Keys arriving with the store full are dropped
// and the set is marked overflowed. The transfer with last_item set closes the set:
// req_stall rises and the block builds a max-heap in the memory with sift-down,
// then extracts the root until the memory is in ascending order. Each sift level
// steps through a left child read, a right child read and a compare with write
// back, and a sift ends in a done step; a build node adds a node read, a capture
// and a done step, and an extraction swap a root read, a tail read, the swap and
// a done step. Results then leave on the rsp_ channel one per cycle while rsp_stall
// is low, smallest first, with last_result on the largest key and overflow on
// every result of a dropped set. The output register holds a result under
// rsp_stall; readout pauses and resumes. After the last result is handed to the
// output register, req_stall falls and the next set may load while that result
// still waits. Reset clears the key count, the overflow flag and the output
// valid; the key memory itself is not cleared and needs no sweep.
module heap_sort_engine
   import hse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   emit_type          emit;
   logic              out_free;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [KEY_W-1:0]  mem_wr_data, mem_rd_data;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   hse_key_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .emit        (emit),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register: free when empty or being transferred this cycle
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = emit.valid ? emit.data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/hse_checker.sv =====
// port-level checks for the heap sort engine and their binding
module hse_checker
   import hse_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input req_type req_data,
   input logic    req_stall,
   input logic    rsp_valid,
   input rsp_type rsp_data,
   input logic    rsp_stall
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // closing a set stops input for the sort
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_item |=> req_stall)
      else $error("input not stalled after last key");

   // input stays closed while a set is still being read out
   a_no_load_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> req_stall)
      else $error("input open during readout");

   // results of one set come in ascending order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_result ##1 rsp_valid
      |-> rsp_data.sorted_key >= $past(rsp_data.sorted_key))
      else $error("results out of order");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);
